/* rtl/core/fcmg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcmg_pkg
// Shared types, register map and reply tables of the message gate.
// ----------------------------------------------------------------------------
package fcmg_pkg;

	localparam int CHANNELS = 4;

	typedef enum logic [2:0] {
		FN_READ  = 3'd0,
		FN_WRITE = 3'd1,
		FN_FRAME = 3'd2,
		FN_PTR   = 3'd3,
		FN_MEDIA = 3'd4
	} func_t;

	localparam logic [3:0] REG_IN0   = 4'd0;
	localparam logic [3:0] REG_OUT0  = 4'd4;
	localparam logic [3:0] REG_STAT0 = 4'd8;
	localparam logic [3:0] REG_ISTAT = 4'd12;
	localparam logic [3:0] REG_IMASK = 4'd13;
	localparam logic [3:0] REG_OPTS  = 4'd14;

	localparam logic [7:0] STAT_BASE  = 8'h01;
	localparam logic [7:0] STAT_EMPTY = 8'h10;
	localparam logic [7:0] PKT_HEAD   = 8'h40;
	localparam logic [7:0] LOW6_MASK  = 8'h3F;

	// Reply byte 0 is the first one popped.
	typedef struct packed {
		logic            hit;
		logic [2:0]      len;
		logic [3:0][7:0] b;
	} reply_t;

	function automatic logic [7:0] irq_bit(input logic [1:0] ch);
		logic [7:0] r;
		r = 8'h00;
		r[{ch, 1'b1}] = 1'b1;
		return r;
	endfunction

	function automatic logic [3:0][7:0] media_reply(input logic present);
		logic [3:0][7:0] s;
		s[0] = 8'hB0;
		if (present) begin
			s[1] = 8'h00; s[2] = 8'h02; s[3] = 8'h15;
		end else begin
			s[1] = 8'h02; s[2] = 8'h10; s[3] = 8'h00;
		end
		return s;
	endfunction

	// Single-byte command table of channel C.
	function automatic reply_t chan_c_reply(input logic [7:0] c);
		reply_t r;
		r.hit = 1'b1;
		r.len = 3'd3;
		r.b   = '0;
		r.b[0] = 8'hA5;
		r.b[1] = c;
		unique case (c)
			8'hF6: begin r.len = 3'd4; r.b[2] = 8'h01; r.b[3] = 8'hFF; end
			8'hF0: begin r.b[2] = 8'h7F; end
			8'hF3: begin r.len = 3'd4; r.b[2] = 8'h4D; end
			8'hF4, 8'hF7, 8'hF8: begin r.b[2] = 8'h00; end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sat8(input logic signed [9:0] v);
		logic [7:0] r;
		if (v < -10'sd128)
			r = 8'h80;
		else if (v > 10'sd127)
			r = 8'h7F;
		else
			r = v[7:0];
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/four_channel_message_gate.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_channel_message_gate
// Bus-side message gate: register reads and writes, frame ticks, pointer
// ticks and media events drive four command/reply channels and an IRQ.
// ----------------------------------------------------------------------------
//   channel | dir | bits | contents
//   s_*     | in  | 40   | func, reg_index, write_data, media_present,
//           |     |      | directions, buttons, mouse_dx, mouse_dy
//   m_*     | out | 16   | read_data, irq_pulse
//
// One word per cycle sustained while the output is not stalled. Each word
// is held in an input register, all state is updated by one pass of logic,
// and the answer goes to an output register, which raises m_tvalid. A stalled
// output holds its word; the input register keeps taking words until it is
// occupied too. Reset clears the valid flags and control state, not payload.
// ----------------------------------------------------------------------------
module four_channel_message_gate
	import fcmg_pkg::*;
#(
	parameter int BUFFER_BYTES      = 8,
	parameter int MAX_POINTER_SPEED = 8,
	parameter int DEFER_FRAMES      = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// func[2:0], reg_index[6:3], write_data[14:7], media_present[15],
	// directions[19:16], buttons[21:20], mouse_dx[29:22], mouse_dy[37:30]
	input  wire logic [39:0] s_tdata,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// read_data[7:0], irq_pulse[8]
	output      logic [15:0] m_tdata
);

	localparam int CW = $clog2(BUFFER_BYTES + 1);

	// input stage
	logic        valid_s1;
	logic [37:0] word_s1;
	logic        adv;

	// output stage
	logic        out_valid_q;
	logic [7:0]  rd_q;
	logic        irq_q;

	// register file parts
	logic [3:0][7:0] in_reg_q, out_reg_q;
	logic [7:0]      istat_q, imask_q;

	// reply stores
	logic [3:0][3:0][7:0] rep_q;
	logic [3:0][2:0]      rep_cnt_q, rep_idx_q;

	// channel D command and held reply
	logic [7:0]      cmd0_q;
	logic [CW-1:0]   cmd_cnt_q;
	logic [3:0][7:0] held_q;
	logic            held_pend_q;
	logic [1:0]      held_fl_q;

	// decoded fields
	func_t             fn;
	logic [3:0]        reg_idx;
	logic [7:0]        wd;
	logic              present;
	logic [3:0]        dirs;
	logic [1:0]        btn;
	logic signed [7:0] mdx, mdy;

	reply_t     ptr_pkt, c_rep;
	logic       ptr_tick;

	// next-state controls
	logic            pub_en;
	logic [1:0]      pub_ch;
	logic [3:0][7:0] pub_b;
	logic [2:0]      pub_len;
	logic            def_en;
	logic [3:0][7:0] def_b;
	logic            pop_en;
	logic [1:0]      pop_ch;
	logic            in_we, mask_we, cmd_store, cmd_clr, held_clr, held_dec;
	logic [7:0]      d_cmd;
	logic [CW-1:0]   d_cnt_nx;
	logic [1:0]      fl_nx;
	logic [7:0]      istat_nx;
	logic [7:0]      rd_nx;
	logic            irq_nx;
	logic [7:0]      pop_byte;
	logic            d_four;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, irq_q, rd_q};

	assign fn      = func_t'(word_s1[2:0]);
	assign reg_idx = word_s1[6:3];
	assign wd      = word_s1[14:7];
	assign present = word_s1[15];
	assign dirs    = word_s1[19:16];
	assign btn     = word_s1[21:20];
	assign mdx     = word_s1[29:22];
	assign mdy     = word_s1[37:30];

	assign ptr_tick = adv && (fn == FN_PTR);

	fcmg_pointer #(
		.MAX_POINTER_SPEED(MAX_POINTER_SPEED)
	) u_pointer (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (ptr_tick),
		.directions (dirs),
		.buttons    (btn),
		.mouse_dx   (mdx),
		.mouse_dy   (mdy),
		.packet     (ptr_pkt)
	);

	assign c_rep = chan_c_reply(wd);

	// Decode the word held in the input stage into state updates.
	always_comb begin
		pub_en = 1'b0; pub_ch = 2'd0; pub_b = '0; pub_len = 3'd4;
		def_en = 1'b0; def_b = '0;
		pop_en = 1'b0; pop_ch = reg_idx[1:0];
		in_we = 1'b0; mask_we = 1'b0;
		cmd_store = 1'b0; cmd_clr = 1'b0;
		held_clr = 1'b0; held_dec = 1'b0;
		fl_nx = held_fl_q;
		d_cmd = (cmd_cnt_q == '0) ? wd : cmd0_q;
		d_cnt_nx = (cmd_cnt_q < CW'(BUFFER_BYTES)) ? cmd_cnt_q + CW'(1) : cmd_cnt_q;
		d_four = (d_cmd == 8'hA1) || (d_cmd == 8'hB0) || (d_cmd == 8'hB2) ||
		         (d_cmd == 8'hE0) || (d_cmd == 8'hE1);
		pop_byte = rep_q[pop_ch][rep_idx_q[pop_ch][1:0]];
		irq_nx = 1'b0;
		rd_nx = 8'd0;

		case (fn)
			FN_READ: begin
				if (reg_idx[3:2] == REG_OUT0[3:2])
					pop_en = rep_cnt_q[pop_ch] > rep_idx_q[pop_ch];
			end
			FN_WRITE: begin
				if (reg_idx == REG_IMASK) begin
					mask_we = 1'b1;
					irq_nx  = (istat_q & wd) != 8'd0;
				end else if (reg_idx[3:2] == REG_IN0[3:2]) begin
					in_we = 1'b1;
					if (reg_idx[1:0] == 2'd2) begin
						pub_en = c_rep.hit; pub_ch = 2'd2;
						pub_b = c_rep.b; pub_len = c_rep.len;
					end else if (reg_idx[1:0] == 2'd3) begin
						// hold a four-byte command until all bytes are in
						if (d_four && d_cnt_nx < CW'(4)) begin
							cmd_store = 1'b1;
						end else begin
							cmd_clr = 1'b1;
							pub_ch = 2'd3;
							if (d_cmd == 8'hA1 || d_cmd == 8'hB0) begin
								def_en = 1'b1; def_b = media_reply(present);
							end else if (d_cmd == 8'hB2) begin
								def_en = 1'b1;
								def_b = {8'h10, 8'h00, 8'h20, 8'hB2};
							end else if (d_cmd == 8'hB1) begin
								pub_en = 1'b1;
								pub_b = {8'h00, 8'h02, 8'h00, 8'hB1};
							end
						end
					end
				end
			end
			FN_FRAME: begin
				if (held_pend_q) begin
					held_dec = 1'b1;
					fl_nx = (held_fl_q != 2'd0) ? held_fl_q - 2'd1 : held_fl_q;
					if (fl_nx == 2'd0) begin
						held_clr = 1'b1;
						pub_en = 1'b1; pub_ch = 2'd3; pub_b = held_q;
					end
				end
			end
			FN_PTR: begin
				pub_en = ptr_pkt.hit; pub_ch = 2'd0; pub_b = ptr_pkt.b;
			end
			FN_MEDIA: begin
				pub_en = 1'b1; pub_ch = 2'd3; pub_b = media_reply(present);
			end
			default: ;
		endcase

		istat_nx = istat_q;
		if (pop_en && (rep_idx_q[pop_ch] + 3'd1 >= rep_cnt_q[pop_ch]))
			istat_nx = istat_nx & ~irq_bit(pop_ch);
		if (pub_en) begin
			istat_nx = istat_nx | irq_bit(pub_ch);
			irq_nx = (imask_q & irq_bit(pub_ch)) != 8'd0;
		end

		if (fn == FN_READ) begin
			case (reg_idx) inside
				[REG_IN0:REG_IN0 + 4'd3]: rd_nx = in_reg_q[reg_idx[1:0]];
				[REG_OUT0:REG_OUT0 + 4'd3]:
					rd_nx = pop_en ? pop_byte : out_reg_q[reg_idx[1:0]];
				[REG_STAT0:REG_STAT0 + 4'd3]: begin
					// status after any pop of this read
					if (rep_cnt_q[reg_idx[1:0]] >
					    rep_idx_q[reg_idx[1:0]] + {2'd0, pop_en})
						rd_nx = STAT_BASE;
					else
						rd_nx = STAT_BASE | STAT_EMPTY;
				end
				REG_ISTAT: rd_nx = istat_q;
				REG_IMASK: rd_nx = imask_q;
				default: rd_nx = 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			in_reg_q    <= '0;
			out_reg_q   <= '0;
			istat_q     <= 8'd0;
			imask_q     <= 8'd0;
			rep_cnt_q   <= '0;
			rep_idx_q   <= '0;
			cmd_cnt_q   <= '0;
			held_pend_q <= 1'b0;
			held_fl_q   <= 2'd0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (adv) begin
				istat_q <= istat_nx;
				if (mask_we)
					imask_q <= wd;
				if (in_we)
					in_reg_q[reg_idx[1:0]] <= wd;
				if (pop_en) begin
					out_reg_q[pop_ch] <= pop_byte;
					rep_idx_q[pop_ch] <= rep_idx_q[pop_ch] + 3'd1;
				end
				if (pub_en) begin
					rep_cnt_q[pub_ch] <= pub_len;
					rep_idx_q[pub_ch] <= 3'd0;
				end
				if (cmd_store)
					cmd_cnt_q <= d_cnt_nx;
				else if (cmd_clr)
					cmd_cnt_q <= '0;
				// restart the frame count on a new deferral
				if (def_en) begin
					held_pend_q <= 1'b1;
					held_fl_q   <= 2'(DEFER_FRAMES);
				end else if (held_dec) begin
					held_fl_q <= fl_nx;
					if (held_clr)
						held_pend_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			word_s1 <= s_tdata[37:0];
		if (adv) begin
			rd_q  <= rd_nx;
			irq_q <= irq_nx;
			if (pub_en)
				rep_q[pub_ch] <= pub_b;
			if (def_en)
				held_q <= def_b;
			if (cmd_store && cmd_cnt_q == '0)
				cmd0_q <= wd;
		end
	end

`ifndef SYNTHESIS
	a_istat_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(istat_q & 8'h55) == 8'h00)
		else $error("interrupt status has a bit outside the channel bits");
	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		held_pend_q |-> held_fl_q != 2'd0)
		else $error("held reply pending with no frames left");
	a_rep_idx: assert property (@(posedge clk) disable iff (!arst_n)
		rep_idx_q[3] <= rep_cnt_q[3] && rep_idx_q[0] <= rep_cnt_q[0])
		else $error("reply index ran past reply count");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output stage");
`endif

endmodule
`default_nettype wire

/* rtl/core/fcmg_pointer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcmg_pointer
// Key repeat counter, button history and motion packet builder.
// ----------------------------------------------------------------------------
module fcmg_pointer
	import fcmg_pkg::*;
#(
	parameter int MAX_POINTER_SPEED = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick,
	input  wire logic [3:0]        directions,
	input  wire logic [1:0]        buttons,
	input  wire logic signed [7:0] mouse_dx,
	input  wire logic signed [7:0] mouse_dy,
	output reply_t                 packet
);

	logic [7:0]        step_q, step_nx;
	logic [1:0]        btn_q;
	logic [8:0]        speed_raw, speed;
	logic signed [9:0] kx, ky, sx, sy;
	logic [7:0]        ex, ey;

	always_comb begin
		if (directions != 4'd0)
			step_nx = (step_q == 8'hFF) ? step_q : step_q + 8'd1;
		else
			step_nx = 8'd0;
		speed_raw = {1'b0, step_nx} + {8'd0, step_nx[0]};
		speed = (speed_raw > 9'(MAX_POINTER_SPEED)) ? 9'(MAX_POINTER_SPEED) : speed_raw;
		kx = directions[0] ? -$signed({1'b0, speed}) :
		     directions[2] ?  $signed({1'b0, speed}) : 10'sd0;
		ky = directions[1] ? -$signed({1'b0, speed}) :
		     directions[3] ?  $signed({1'b0, speed}) : 10'sd0;
		sx = kx + 10'(mouse_dx);
		sy = ky + 10'(mouse_dy);
		ex = sat8(sx);
		ey = sat8(sy);
		packet.hit = (directions != 4'd0) || (ex != 8'd0) || (ey != 8'd0) ||
		             ((buttons ^ btn_q) != 2'd0);
		packet.len  = 3'd4;
		packet.b[0] = PKT_HEAD | {2'b00, buttons[0], buttons[1], ey[7:6], ex[7:6]};
		packet.b[1] = ex & LOW6_MASK;
		packet.b[2] = ey & LOW6_MASK;
		packet.b[3] = 8'h00;
	end

	// Advance repeat count and button history on each report tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 8'd0;
			btn_q  <= 2'd0;
		end else if (tick) begin
			step_q <= step_nx;
			btn_q  <= buttons;
		end
	end

endmodule
`default_nettype wire

/* sim/tb_four_channel_message_gate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_channel_message_gate
// Self-checking bench for the message gate: a queue-fed driver sends bus
// words, a behavioral copy of the gate predicts each answer word, and the
// monitor compares every answer word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_four_channel_message_gate;
	import fcmg_pkg::*;

	localparam int BUF_BYTES  = 8;
	localparam int MAX_SPEED  = 8;
	localparam int DEFER_CNT  = 2;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic signed [7:0] mouse_dy;
		logic signed [7:0] mouse_dx;
		logic [1:0]        buttons;
		logic [3:0]        directions;
		logic              media_present;
		logic [7:0]        write_data;
		logic [3:0]        reg_index;
		logic [2:0]        func;
	} bus_word_t;

	typedef struct packed {
		logic       irq_pulse;
		logic [7:0] read_data;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	four_channel_message_gate dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Predictor state
	logic [7:0] regs [15];
	logic [7:0] cmd_buf [4][BUF_BYTES];
	int         cmd_cnt [4];
	logic [7:0] rep_buf [4][BUF_BYTES];
	int         rep_cnt [4];
	int         rep_idx [4];
	logic [7:0] held_buf [4][4];
	logic       held_on [4];
	int         held_frames [4];
	int         repeat_cnt;
	logic [1:0] prev_btn;

	bus_word_t pending_words [$];
	answer_t   expected_answers [$];
	int        errors;
	int        stall_hold;
	logic      sink_hold_req;
	int        long_hold;
	logic      in_taken = 1'b0;

	function automatic logic [7:0] chan_mask(int ch);
		return 8'h02 << (2 * ch);
	endfunction

	function automatic void model_reset();
		for (int i = 0; i < 15; i++) regs[i] = 8'h00;
		for (int ch = 0; ch < 4; ch++) begin
			regs[REG_STAT0 + ch] = 8'h11;
			cmd_cnt[ch] = 0; rep_cnt[ch] = 0; rep_idx[ch] = 0;
			held_on[ch] = 1'b0; held_frames[ch] = 0;
		end
		repeat_cnt = 0;
		prev_btn = 2'b00;
	endfunction

	function automatic void refresh_status(int ch);
		if (rep_cnt[ch] > rep_idx[ch])
			regs[REG_STAT0 + ch] = regs[REG_STAT0 + ch] & 8'h01;
		else
			regs[REG_STAT0 + ch] = regs[REG_STAT0 + ch] | 8'h11;
	endfunction

	function automatic logic post_reply(int ch, logic [7:0] b0, logic [7:0] b1,
		logic [7:0] b2, logic [7:0] b3, int len);
		rep_buf[ch][0] = b0; rep_buf[ch][1] = b1;
		rep_buf[ch][2] = b2; rep_buf[ch][3] = b3;
		rep_cnt[ch] = len;
		rep_idx[ch] = 0;
		refresh_status(ch);
		regs[REG_ISTAT] = regs[REG_ISTAT] | chan_mask(ch);
		return (regs[REG_IMASK] & chan_mask(ch)) != 0;
	endfunction

	function automatic void hold_reply(int ch, logic [7:0] b0, logic [7:0] b1,
		logic [7:0] b2, logic [7:0] b3);
		held_buf[ch][0] = b0; held_buf[ch][1] = b1;
		held_buf[ch][2] = b2; held_buf[ch][3] = b3;
		held_on[ch] = 1'b1;
		held_frames[ch] = DEFER_CNT;
	endfunction

	function automatic logic chan_c_cmd();
		logic [7:0] c;
		c = cmd_buf[2][0];
		cmd_cnt[2] = 0;
		case (c)
			8'hF6: return post_reply(2, 8'hA5, c, 8'h01, 8'hFF, 4);
			8'hF0: return post_reply(2, 8'hA5, c, 8'h7F, 8'h00, 3);
			8'hF3: return post_reply(2, 8'hA5, c, 8'h4D, 8'h00, 4);
			8'hF4, 8'hF7, 8'hF8: return post_reply(2, 8'hA5, c, 8'h00, 8'h00, 3);
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic chan_d_cmd(logic present);
		logic [7:0] c;
		logic       p;
		logic       four;
		c = cmd_buf[3][0];
		p = 1'b0;
		four = (c == 8'hA1 || c == 8'hB0 || c == 8'hB2 || c == 8'hE0 || c == 8'hE1);
		if (four && cmd_cnt[3] < 4) return 1'b0;
		if (c == 8'hA1 || c == 8'hB0) begin
			if (present) hold_reply(3, 8'hB0, 8'h00, 8'h02, 8'h15);
			else hold_reply(3, 8'hB0, 8'h02, 8'h10, 8'h00);
		end else if (c == 8'hB1) begin
			p = post_reply(3, 8'hB1, 8'h00, 8'h02, 8'h00, 4);
		end else if (c == 8'hB2) begin
			hold_reply(3, 8'hB2, 8'h20, 8'h00, 8'h10);
		end
		cmd_cnt[3] = 0;
		return p;
	endfunction

	function automatic logic [7:0] clamp8(int v);
		if (v < -128) v = -128;
		if (v > 127) v = 127;
		return v[7:0];
	endfunction

	function automatic logic pointer_report(bus_word_t w);
		int         speed;
		int         x;
		int         y;
		logic [7:0] ex;
		logic [7:0] ey;
		logic [1:0] changed;
		logic       p;
		x = 0; y = 0; p = 1'b0;
		changed = w.buttons ^ prev_btn;
		if (w.directions != 0) begin
			if (repeat_cnt < 255) repeat_cnt++;
		end else begin
			repeat_cnt = 0;
		end
		speed = repeat_cnt + (repeat_cnt & 1);
		if (speed > MAX_SPEED) speed = MAX_SPEED;
		if (w.directions[0]) x = -speed; else if (w.directions[2]) x = speed;
		if (w.directions[1]) y = -speed; else if (w.directions[3]) y = speed;
		x += int'(w.mouse_dx);
		y += int'(w.mouse_dy);
		ex = clamp8(x);
		ey = clamp8(y);
		if (w.directions != 0 || ex != 0 || ey != 0 || changed != 0)
			p = post_reply(0,
				PKT_HEAD | (w.buttons[0] ? 8'h20 : 8'h00) | (w.buttons[1] ? 8'h10 : 8'h00)
					| ((ey >> 4) & 8'h0C) | ((ex >> 6) & 8'h03),
				ex & LOW6_MASK, ey & LOW6_MASK, 8'h00, 4);
		prev_btn = w.buttons;
		return p;
	endfunction

	// Advance the gate copy by one bus word and return the answer it produces.
	function automatic answer_t gate_answer(bus_word_t w);
		answer_t a;
		int      ch;
		a = '0;
		case (w.func)
			FN_READ: begin
				if (w.reg_index < 15) begin
					if (w.reg_index >= REG_OUT0 && w.reg_index < REG_STAT0) begin
						ch = w.reg_index - REG_OUT0;
						if (rep_cnt[ch] > rep_idx[ch]) begin
							regs[w.reg_index] = rep_buf[ch][rep_idx[ch]];
							rep_idx[ch]++;
							if (rep_idx[ch] >= rep_cnt[ch])
								regs[REG_ISTAT] = regs[REG_ISTAT] & ~chan_mask(ch);
							refresh_status(ch);
						end
					end
					a.read_data = regs[w.reg_index];
				end
			end
			FN_WRITE: begin
				if (w.reg_index == REG_IMASK) begin
					regs[REG_IMASK] = w.write_data;
					a.irq_pulse = (regs[REG_ISTAT] & w.write_data) != 0;
				end else if (w.reg_index < REG_OUT0) begin
					ch = w.reg_index;
					regs[ch] = w.write_data;
					if (cmd_cnt[ch] < BUF_BYTES) begin
						cmd_buf[ch][cmd_cnt[ch]] = w.write_data;
						cmd_cnt[ch]++;
					end
					if (ch == 2) a.irq_pulse = chan_c_cmd();
					else if (ch == 3) a.irq_pulse = chan_d_cmd(w.media_present);
				end
			end
			FN_FRAME: begin
				for (int c = 0; c < 4; c++) begin
					if (held_on[c]) begin
						if (held_frames[c] > 0) held_frames[c]--;
						if (held_frames[c] == 0) begin
							a.irq_pulse |= post_reply(c, held_buf[c][0], held_buf[c][1],
								held_buf[c][2], held_buf[c][3], 4);
							held_on[c] = 1'b0;
						end
					end
				end
			end
			FN_PTR: a.irq_pulse = pointer_report(w);
			FN_MEDIA: begin
				if (w.media_present)
					a.irq_pulse = post_reply(3, 8'hB0, 8'h00, 8'h02, 8'h15, 4);
				else
					a.irq_pulse = post_reply(3, 8'hB0, 8'h02, 8'h10, 8'h00, 4);
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic bus_word_t rand_word();
		bus_word_t w;
		w = bus_word_t'(38'({$urandom, $urandom}));
		w.func = 3'($urandom_range(0, 7));
		return w;
	endfunction

	function automatic bus_word_t mk(logic [2:0] f, logic [3:0] r, logic [7:0] d);
		bus_word_t w;
		w = rand_word();
		w.func = f; w.reg_index = r; w.write_data = d;
		return w;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Queue a command, pointer run, media event, mask write or random word, then reply and status reads.
	task automatic queue_sequence();
		bus_word_t  w;
		logic [7:0] cmds_c [6];
		logic [7:0] cmds_d [6];
		int         ch;
		cmds_c = '{8'hF6, 8'hF0, 8'hF3, 8'hF4, 8'hF7, 8'hF8};
		cmds_d = '{8'hA1, 8'hB0, 8'hB1, 8'hB2, 8'hE0, 8'hE1};
		case ($urandom_range(0, 5))
			0: pending_words.push_back(mk(FN_WRITE, REG_IN0 + 4'd2,
				($urandom_range(0, 5) == 0) ? 8'($urandom) : cmds_c[$urandom_range(0, 5)]));
			1: begin
				pending_words.push_back(mk(FN_WRITE, REG_IN0 + 4'd3,
					($urandom_range(0, 7) == 0) ? 8'($urandom) : cmds_d[$urandom_range(0, 5)]));
				repeat ($urandom_range(0, 4))
					pending_words.push_back(mk(FN_WRITE, REG_IN0 + 4'd3, 8'($urandom)));
				repeat ($urandom_range(0, 3))
					pending_words.push_back(mk(FN_FRAME, 4'($urandom), 8'($urandom)));
			end
			2: begin
				w = rand_word();
				w.func = FN_PTR;
				if ($urandom_range(0, 3) != 0) begin
					w.mouse_dx = 8'($signed($urandom_range(0, 8)) - 4);
					w.mouse_dy = 8'($signed($urandom_range(0, 8)) - 4);
				end
				repeat ($urandom_range(1, 12)) begin
					pending_words.push_back(w);
					if ($urandom_range(0, 3) == 0) w.directions = 4'($urandom);
				end
			end
			3: pending_words.push_back(mk(FN_MEDIA, 4'($urandom), 8'($urandom)));
			4: pending_words.push_back(mk(FN_WRITE, REG_IMASK, 8'($urandom)));
			default: pending_words.push_back(rand_word());
		endcase
		ch = $urandom_range(0, 3);
		repeat ($urandom_range(0, 5))
			pending_words.push_back(mk(FN_READ, REG_OUT0 + 4'(ch), 8'($urandom)));
		pending_words.push_back(mk(FN_READ, ($urandom_range(0, 1)) ? REG_STAT0 + 4'(ch)
			: 4'($urandom_range(REG_ISTAT, 15)), 8'($urandom)));
	endtask

	// Driver: present the next queued word on the falling edge, idling at random.
	// The accept is taken from the rising edge, not from the ready seen now.
	int gap_left;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				void'(pending_words.pop_front());
				gap_left = gap_len();
			end
			if (!s_tvalid || in_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, pending_words[0]};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver readiness: random stalls, or a long hold-off when requested.
	always @(negedge clk) begin
		if (long_hold > 0) begin
			long_hold--;
			m_tready <= 1'b0;
		end else if (sink_hold_req) begin
			long_hold = 300;
			m_tready <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			stall_hold = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		end
	end

	// Predict on input accept, check on output accept.
	int idle_cycles;
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (arst_n) begin
			idle_cycles++;
			in_taken = s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				expected_answers.push_back(gate_answer(bus_word_t'(s_tdata[37:0])));
				idle_cycles = 0;
			end
			if (m_tvalid && m_tready) begin
				idle_cycles = 0;
				got = answer_t'(m_tdata[8:0]);
				if (expected_answers.size() == 0) begin
					errors++;
					$display("%0t: unexpected answer word, expected none, got %h", $time, got);
				end else begin
					want = expected_answers.pop_front();
					if (got.read_data !== want.read_data) begin
						errors++;
						$display("%0t: read_data mismatch, expected %h, got %h",
							$time, want.read_data, got.read_data);
					end
					if (got.irq_pulse !== want.irq_pulse) begin
						errors++;
						$display("%0t: irq_pulse mismatch, expected %b, got %b",
							$time, want.irq_pulse, got.irq_pulse);
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** four_channel_message_gate: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] c_cmds [6];
		c_cmds = '{8'hF6, 8'hF0, 8'hF3, 8'hF4, 8'hF7, 8'hF8};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		sink_hold_req = 1'b0;
		long_hold = 0;
		stall_hold = 0;
		gap_left = 0;
		errors = 0;
		idle_cycles = 0;
		model_reset();

		// Directed: every register, mask pulse, deferred and immediate replies.
		pending_words.push_back(mk(FN_WRITE, REG_IMASK, 8'hFF));
		for (int i = 0; i < 6; i++) pending_words.push_back(mk(FN_WRITE, 4'd2, c_cmds[i]));
		pending_words.push_back(mk(FN_WRITE, 4'd2, 8'h00));
		pending_words.push_back(mk(FN_WRITE, 4'd3, 8'hB0));
		pending_words.push_back(mk(FN_WRITE, 4'd3, 8'h00));
		pending_words.push_back(mk(FN_WRITE, 4'd3, 8'h00));
		pending_words.push_back(mk(FN_WRITE, 4'd3, 8'hFF));
		pending_words.push_back(mk(FN_WRITE, 4'd3, 8'hB2));
		pending_words.push_back(mk(FN_WRITE, 4'd3, 8'hB1));
		pending_words.push_back(mk(FN_FRAME, 4'd0, 8'h00));
		pending_words.push_back(mk(FN_FRAME, 4'd0, 8'h00));
		for (int i = 0; i < 10; i++) pending_words.push_back(mk(FN_WRITE, 4'd0, 8'(i)));
		pending_words.push_back(mk(FN_MEDIA, 4'd0, 8'h00));
		for (int r = 0; r < 16; r++) pending_words.push_back(mk(FN_READ, 4'(r), 8'h00));
		for (int i = 0; i < 6; i++) pending_words.push_back(mk(FN_READ, REG_OUT0 + 4'd3, 8'h00));
		pending_words.push_back(mk(FN_WRITE, REG_OPTS, 8'hFF));
		pending_words.push_back(mk(FN_WRITE, 4'd15, 8'hFF));
		begin
			bus_word_t w;
			w = mk(FN_PTR, 4'd0, 8'h00);
			w.directions = 4'hF; w.buttons = 2'b11;
			w.mouse_dx = 8'sh7F; w.mouse_dy = -8'sd128;
			repeat (3) pending_words.push_back(w);
			w.directions = 4'h0; w.buttons = 2'b00; w.mouse_dx = 0; w.mouse_dy = 0;
			pending_words.push_back(w);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_words.size() == 0);
		// Pause the sender until every answer is back.
		wait (expected_answers.size() == 0);

		// Long receiver hold-off while the sender keeps offering.
		for (int i = 0; i < 40; i++) pending_words.push_back(rand_word());
		sink_hold_req = 1'b1;
		@(posedge clk);
		sink_hold_req = 1'b0;

		while (pending_words.size() < 1200) queue_sequence();
		// Run the saturation of the repeat count once.
		begin
			bus_word_t w;
			w = mk(FN_PTR, 4'd0, 8'h00);
			w.directions = 4'h4;
			repeat (270) pending_words.push_back(w);
		end
		repeat (20) queue_sequence();

		wait (pending_words.size() == 0);
		wait (expected_answers.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("** four_channel_message_gate: PASSED **");
		else
			$display("** four_channel_message_gate: FAILED **");
		$finish;
	end

endmodule
